@@ hdl/bucket_sort_unit_interval_defines.svh @@
// ----------------------------------------------------------------------------
// bucket_sort_unit_interval assertion macros
// shared assertion forms for the sort block
// ----------------------------------------------------------------------------
`ifndef BUCKET_SORT_UNIT_INTERVAL_DEFINES_SVH
`define BUCKET_SORT_UNIT_INTERVAL_DEFINES_SVH

// same-cycle implication
`define BSUI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsui check failed");

// next-cycle implication
`define BSUI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsui check failed");

`endif

@@ hdl/bsui_pkg.sv @@
// ----------------------------------------------------------------------------
// bsui_pkg
// types and constants for the unit-interval sort block
// ----------------------------------------------------------------------------
package bsui_pkg;

    localparam int VALUE_BITS = 16;
    localparam int MAX_ITEMS  = 64;
    localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] sample_value;
        logic                  batch_end;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sorted_value;
        logic                  final_item;
        logic                  overflow_seen;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_CMP,
        ST_DRD,
        ST_DWAIT,
        ST_DOUT
    } t_state;

    typedef struct packed {
        logic load;
        logic wr_val;
        logic rd;
        logic shift;
        logic drd;
        logic dload;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic j_zero;
        logic gt;
        logic out_taken;
        logic out_last;
    } t_status;

endpackage

@@ hdl/bsui_ram.sv @@
// ----------------------------------------------------------------------------
// bsui_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module bsui_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/bsui_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsui_ctrl
// sequencer for insertion, drain and batch clear
// ----------------------------------------------------------------------------
module bsui_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bsui_pkg::t_status i_status,
    output bsui_pkg::t_cmd    o_cmd
);
    import bsui_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (i_status.full) begin
                    n_state = i_status.last ? ST_DRD : ST_LOAD;
                end else if (i_status.j_zero) begin
                    n_state = i_status.last ? ST_DRD : ST_LOAD;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_status.gt) begin
                    n_state = ST_RD;
                end else begin
                    n_state = i_status.last ? ST_DRD : ST_LOAD;
                end
            end
            ST_DRD:   n_state = ST_DWAIT;
            ST_DWAIT: n_state = ST_DOUT;
            ST_DOUT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.out_last ? ST_LOAD : ST_DRD;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_RD: begin
                if (!i_status.full) begin
                    if (i_status.j_zero) begin
                        o_cmd.wr_val = 1'b1;
                    end else begin
                        o_cmd.rd = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                if (i_status.gt) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.wr_val = 1'b1;
                end
            end
            ST_DRD:   o_cmd.drd = 1'b1;
            ST_DWAIT: o_cmd.dload = 1'b1;
            ST_DOUT: begin
                o_cmd.clear = i_status.out_taken && i_status.out_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

@@ hdl/bsui_dp.sv @@
// ----------------------------------------------------------------------------
// bsui_dp
// value store, insertion pointer, drain counter and result register
// ----------------------------------------------------------------------------
`include "bucket_sort_unit_interval_defines.svh"

module bsui_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsui_pkg::t_in_item  i_data,
    input  logic                i_stall,
    output logic                o_valid,
    output bsui_pkg::t_out_item o_data,
    input  bsui_pkg::t_cmd      i_cmd,
    output bsui_pkg::t_status   o_status
);
    import bsui_pkg::*;

    logic [VALUE_BITS-1:0] r_val;
    logic                  r_last;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   r_j;
    logic [CNT_BITS-1:0]   r_k;
    logic                  r_ovf;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [CNT_BITS-1:0]   j_dec;
    logic [CNT_BITS-1:0]   k_inc;
    logic                  full;

    assign full  = (r_count == CNT_BITS'(MAX_ITEMS));
    assign j_dec = r_j - CNT_BITS'(1);
    assign k_inc = r_k + CNT_BITS'(1);

    assign ram_we    = i_cmd.wr_val || i_cmd.shift;
    assign ram_waddr = r_j[ADDR_BITS-1:0];
    assign ram_wdata = i_cmd.shift ? ram_rdata : r_val;
    assign ram_raddr = i_cmd.drd ? r_k[ADDR_BITS-1:0] : j_dec[ADDR_BITS-1:0];

    bsui_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_data.sample_value;
            r_last <= i_data.batch_end;
        end
        if (i_cmd.dload) begin
            r_out.sorted_value  <= ram_rdata;
            r_out.final_item    <= (k_inc == r_count);
            r_out.overflow_seen <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_j <= r_count;
                if (full) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.shift) begin
                r_j <= j_dec;
            end
            if (i_cmd.wr_val) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            if (i_cmd.dload) begin
                r_k         <= k_inc;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_k     <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign o_status.full      = full;
    assign o_status.last      = r_last;
    assign o_status.j_zero    = (r_j == '0);
    assign o_status.gt        = (ram_rdata > r_val);
    assign o_status.out_taken = r_out_valid && !i_stall;
    assign o_status.out_last  = r_out.final_item;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BSUI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(MAX_ITEMS))
    `BSUI_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, (r_count == '0) && !r_ovf)
    `BSUI_ASSERT_NOW(a_shift_nonzero, i_clk, i_rst_n, i_cmd.shift, r_j != '0)
    `BSUI_ASSERT_NOW(a_read_nonzero, i_clk, i_rst_n, i_cmd.rd, r_j != '0)
    `BSUI_ASSERT_NOW(a_write_not_full, i_clk, i_rst_n, i_cmd.wr_val, !full)
endmodule

@@ hdl/bucket_sort_unit_interval.sv @@
// ----------------------------------------------------------------------------
// bucket_sort_unit_interval
// sorts a batch of q0.16 fractions ascending and streams them out
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// input   | in        | i_valid / o_stall    | i_data  (sample_value, batch_end)
// output  | out       | o_valid / i_stall    | o_data  (sorted_value, final_item,
//         |           |                      |          overflow_seen)
//
// an item steps through the read and compare states once per stored value above it,
// and only through the read state when it lands at the front or is dropped from a full store
// (the store has a single read port, so each shift needs a read and then a compare)
// each result of a drain passes the read, wait and output states and waits out any stall on the output
// a batch end item starts the drain; no item is taken until it finishes
// synchronous active-low reset empties the batch; the store needs no clearing
// ----------------------------------------------------------------------------
module bucket_sort_unit_interval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bsui_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output bsui_pkg::t_out_item o_data
);
    import bsui_pkg::*;

    t_cmd    cmd;
    t_status status;

    bsui_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(status),
        .o_cmd   (cmd)
    );

    bsui_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_cmd   (cmd),
        .o_status(status)
    );
endmodule
